### rtl/bsso_pkg.sv
// ----------------------------------------------------------------------------
// bsso_pkg
// Shared types and constants for the selectable-order bubble sorter.
// ----------------------------------------------------------------------------
package bsso_pkg;

  // store geometry
  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam int DATA_W   = 32;

  // remainder unit: one quotient bit per cycle
  localparam int DIV_STEPS = DATA_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // configuration port
  localparam int ADDR_W = 3;
  localparam logic REG_COMPARE_MODE = 1'b0;

  // compare_mode codes
  localparam logic [1:0] MODE_ASC     = 2'd0;
  localparam logic [1:0] MODE_DESC    = 2'd1;
  localparam logic [1:0] MODE_STRANGE = 2'd2;

  // request from the sequencer to the compare unit
  typedef struct packed {
    logic       start;
    logic [1:0] mode;
  } cmp_req_t;

  // answer from the compare unit
  typedef struct packed {
    logic done;
    logic swap;
  } cmp_resp_t;

endpackage

### rtl/bubble_sort_selectable_order.sv
// ----------------------------------------------------------------------------
// bubble_sort_selectable_order
// Collects signed numbers into a 32-entry store, bubble sorts them in the
// order chosen by compare_mode and streams the sorted set out.
// ----------------------------------------------------------------------------
// usage
//   input: a transaction is taken at a clock edge with start high and busy
//   low. items without is_last are stored. an item with is_last starts the
//   sort of the held set (n entries) and raises busy.
//   sort: n full passes of n-1 compare-swap steps through one shared compare
//   unit and a single-port-read store. in the remainder order a step whose
//   pair needs a division waits for the restoring divider. each pass adds
//   the states S_PASS_START, S_LOAD_A and S_PASS_END around its steps.
//   config: compare_mode at byte address 0 must be written by the user only
//   while idle; the block itself does not enforce this.
//   output: n results, one per cycle on result_valid; last_out marks the last
//   one, overflow is set on all of them if numbers were dropped. busy falls
//   the cycle after the last result. the receiver cannot stall the stream.
//   a full store drops new numbers; a dropped item with is_last still sorts.
//   reset: synchronous; empties the store, clears the dropped flag and sets
//   compare_mode to ascending. store contents need no clearing.
// ----------------------------------------------------------------------------
module bubble_sort_selectable_order (
  input  logic                               clk,
  input  logic                               rst,
  // apb configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bsso_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // input transactions
  input  logic                               start,
  output logic                               busy,
  input  logic signed [bsso_pkg::DATA_W-1:0] value,
  input  logic                               is_last,
  // results
  output logic                               result_valid,
  output logic signed [bsso_pkg::DATA_W-1:0] sorted_value,
  output logic                               last_out,
  output logic                               overflow
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS_START,
    S_LOAD_A,
    S_LOAD_B,
    S_CMP,
    S_PASS_END,
    S_OUT,
    S_DONE
  } seq_state_t;

  seq_state_t state;

  // control registers
  logic [bsso_pkg::CNT_W-1:0]  fill_count;
  logic                        dropped_flag;
  logic [1:0]                  compare_mode;
  logic [bsso_pkg::CNT_W-1:0]  n;
  logic [bsso_pkg::CNT_W-1:0]  pass;
  logic [bsso_pkg::IDX_W-1:0]  j;
  logic [bsso_pkg::IDX_W-1:0]  k;
  logic                        out_valid;
  logic                        out_last;

  // datapath registers
  logic signed [bsso_pkg::DATA_W-1:0] carry;
  logic signed [bsso_pkg::DATA_W-1:0] b_hold;
  logic signed [bsso_pkg::DATA_W-1:0] rd_data;

  // value store
  logic signed [bsso_pkg::DATA_W-1:0] value_store [bsso_pkg::CAPACITY];

  logic                               mem_we;
  logic [bsso_pkg::IDX_W-1:0]         mem_waddr;
  logic signed [bsso_pkg::DATA_W-1:0] mem_wdata;
  logic [bsso_pkg::IDX_W-1:0]         mem_raddr;

  logic                        accept;
  logic                        has_room;
  logic [bsso_pkg::CNT_W-1:0]  n_new;
  logic [bsso_pkg::CNT_W-1:0]  n_minus1;
  logic                        more_pairs;
  logic                        cfg_write;

  bsso_pkg::cmp_req_t  cmp_req;
  bsso_pkg::cmp_resp_t cmp_resp;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign has_room  = (fill_count < bsso_pkg::CAP_CNT);
  assign n_new     = has_room ? fill_count + 1'b1 : fill_count;
  assign n_minus1  = n - 1'b1;
  // another pair after j, i.e. j+2 < n
  assign more_pairs = (bsso_pkg::CNT_W'(j) + bsso_pkg::CNT_W'(2)) < n;

  // shared compare unit; operand a is the value carried along the pass
  assign cmp_req.start = (state == S_LOAD_B);
  assign cmp_req.mode  = compare_mode;

  bsso_cmp_unit u_cmp (
    .clk  (clk),
    .rst  (rst),
    .req  (cmp_req),
    .a    (carry),
    .b    (rd_data),
    .resp (cmp_resp)
  );

  // store write port: load, step write-back, pass tail
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = carry;
    unique case (state)
      S_IDLE: begin
        mem_we    = accept && has_room;
        mem_waddr = fill_count[bsso_pkg::IDX_W-1:0];
        mem_wdata = value;
      end
      S_CMP: begin
        mem_we    = cmp_resp.done;
        mem_waddr = j;
        mem_wdata = cmp_resp.swap ? b_hold : carry;
      end
      S_PASS_END: begin
        mem_we    = 1'b1;
        mem_waddr = n_minus1[bsso_pkg::IDX_W-1:0];
        mem_wdata = carry;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // store read port, read data is registered and comes back the next cycle
  always_comb begin
    unique case (state)
      S_PASS_START: mem_raddr = '0;
      S_LOAD_A:     mem_raddr = j + 1'b1;
      S_CMP:        mem_raddr = j + 2'd2;
      S_OUT:        mem_raddr = k;
      default:      mem_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      value_store[mem_waddr] <= mem_wdata;
    end
    rd_data <= value_store[mem_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill_count   <= '0;
      dropped_flag <= 1'b0;
      out_valid    <= 1'b0;
      out_last     <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      out_last  <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (has_room) begin
              fill_count <= fill_count + 1'b1;
            end else begin
              dropped_flag <= 1'b1;
            end
            if (is_last) begin
              n    <= n_new;
              pass <= '0;
              j    <= '0;
              k    <= '0;
              // a single number needs no pass
              if (n_new > bsso_pkg::CNT_W'(1)) begin
                state <= S_PASS_START;
              end else begin
                state <= S_OUT;
              end
            end
          end
        end
        S_PASS_START: begin
          state <= S_LOAD_A;
        end
        S_LOAD_A: begin
          carry <= rd_data;
          state <= S_LOAD_B;
        end
        S_LOAD_B: begin
          b_hold <= rd_data;
          state  <= S_CMP;
        end
        S_CMP: begin
          if (cmp_resp.done) begin
            // the value that belongs on the right of the pair keeps moving right
            if (!cmp_resp.swap) begin
              carry <= b_hold;
            end
            if (more_pairs) begin
              j     <= j + 1'b1;
              state <= S_LOAD_B;
            end else begin
              state <= S_PASS_END;
            end
          end
        end
        S_PASS_END: begin
          j    <= '0;
          pass <= pass + 1'b1;
          if ((pass + 1'b1) < n) begin
            state <= S_PASS_START;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          out_last  <= ((bsso_pkg::CNT_W'(k) + 1'b1) == n);
          k         <= k + 1'b1;
          if ((bsso_pkg::CNT_W'(k) + 1'b1) == n) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // last result is on the ports this cycle
          fill_count   <= '0;
          dropped_flag <= 1'b0;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result_valid = out_valid;
  assign sorted_value = rd_data;
  assign last_out     = out_last;
  assign overflow     = dropped_flag;

  // configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      compare_mode <= bsso_pkg::MODE_ASC;
    end else if (cfg_write && (paddr[2] == bsso_pkg::REG_COMPARE_MODE)) begin
      compare_mode <= pwdata[1:0];
    end
  end

  // byte offset within the register is ignored
  always_comb begin
    if (paddr[2] == bsso_pkg::REG_COMPARE_MODE) begin
      prdata = {30'd0, compare_mode};
    end else begin
      prdata = '0;
    end
  end

  // results only stream while the sorter is busy
  a_result_busy : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result outside a busy period");

  // the burst ends and the block reopens right after the last result
  a_last_idle : assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_out) |=> (!result_valid && !busy))
    else $error("activity after last result");

  // the compare unit answers only while a step waits for it
  a_cmp_done : assert property (@(posedge clk) disable iff (rst)
    cmp_resp.done |-> (state == S_CMP))
    else $error("compare answer outside a step");

  // a compared pair always lies inside the held set
  a_pair_range : assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> ((bsso_pkg::CNT_W'(j) + bsso_pkg::CNT_W'(1)) < n))
    else $error("pair index beyond set");

endmodule

### rtl/bsso_cmp_unit.sv
// ----------------------------------------------------------------------------
// bsso_cmp_unit
// Decides whether a neighbor pair is swapped; the remainder order runs a
// restoring divider one bit per cycle.
// ----------------------------------------------------------------------------
module bsso_cmp_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  bsso_pkg::cmp_req_t               req,
  input  logic signed [bsso_pkg::DATA_W-1:0] a,
  input  logic signed [bsso_pkg::DATA_W-1:0] b,
  output bsso_pkg::cmp_resp_t              resp
);

  typedef enum logic {
    C_IDLE,
    C_DIV
  } cmp_state_t;

  cmp_state_t                    state;
  logic [bsso_pkg::DATA_W-1:0]   rem;
  logic [bsso_pkg::DATA_W-1:0]   dvd;
  logic [bsso_pkg::DATA_W-1:0]   dvs;
  logic [bsso_pkg::STEP_W-1:0]   step;
  logic                          done;
  logic                          swap;

  logic [bsso_pkg::DATA_W:0]     rem_shift;
  logic [bsso_pkg::DATA_W:0]     rem_next;
  logic                          trivial_no;

  // one restoring step
  always_comb begin
    rem_shift = {rem, dvd[bsso_pkg::DATA_W-1]};
    if (rem_shift >= {1'b0, dvs}) begin
      rem_next = rem_shift - {1'b0, dvs};
    end else begin
      rem_next = rem_shift;
    end
  end

  // no division needed: dividend not positive, divisor zero or divisor minus one
  assign trivial_no = (a <= 0) || (b == 0) || (b == -32'sd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
      swap  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (req.start) begin
            unique case (req.mode)
              bsso_pkg::MODE_ASC: begin
                done <= 1'b1;
                swap <= (a > b);
              end
              bsso_pkg::MODE_DESC: begin
                done <= 1'b1;
                swap <= (b > a);
              end
              bsso_pkg::MODE_STRANGE: begin
                if (trivial_no) begin
                  done <= 1'b1;
                  swap <= 1'b0;
                end else begin
                  rem   <= '0;
                  dvd   <= a;
                  dvs   <= (b < 0) ? -b : b;
                  step  <= '0;
                  state <= C_DIV;
                end
              end
              default: begin
                done <= 1'b1;
                swap <= 1'b0;
              end
            endcase
          end
        end
        C_DIV: begin
          rem  <= rem_next[bsso_pkg::DATA_W-1:0];
          dvd  <= {dvd[bsso_pkg::DATA_W-2:0], 1'b0};
          step <= step + 1'b1;
          if (step == bsso_pkg::STEP_W'(bsso_pkg::DIV_STEPS - 1)) begin
            done  <= 1'b1;
            swap  <= (rem_next[bsso_pkg::DATA_W-1:0] != '0);
            state <= C_IDLE;
          end
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

  assign resp.done = done;
  assign resp.swap = swap;

endmodule

### bench/bubble_sort_selectable_order_tb.sv
// ----------------------------------------------------------------------------
// bubble_sort_selectable_order_tb
// Self-checking bench for the selectable-order bubble sorter. Sets of signed
// numbers are loaded through the start/busy port. Each sorted burst is checked
// against a local sorting predictor, field by field, across all compare
// orders, dropped numbers on a full store, and register writes made while idle.
// ----------------------------------------------------------------------------
module bubble_sort_selectable_order_tb;

  // timing and run limits
  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 10;
  localparam int SETTLE_GAP   = 8;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int DRAIN_LIMIT  = 200_000;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS   = 52;

  // mode code with no order defined, never swaps
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // register map: compare_mode at byte 0, byte 4 holds no register
  localparam logic [bsso_pkg::ADDR_W-1:0] ADDR_COMPARE_MODE =
    bsso_pkg::ADDR_W'(4 * bsso_pkg::REG_COMPARE_MODE);
  localparam logic [bsso_pkg::ADDR_W-1:0] ADDR_NO_REG = bsso_pkg::ADDR_W'(4);

  // extreme numbers
  localparam logic signed [bsso_pkg::DATA_W-1:0] NUM_MAX = 32'sh7fff_ffff;
  localparam logic signed [bsso_pkg::DATA_W-1:0] NUM_MIN = 32'sh8000_0000;

  // one number waiting to be loaded, with the idle cycles before it
  typedef struct {
    logic signed [bsso_pkg::DATA_W-1:0] number;
    logic                               last;
    int                                 gap;
  } load_item_t;

  // one expected entry of a sorted burst
  typedef struct {
    logic signed [bsso_pkg::DATA_W-1:0] number;
    logic                               last;
    logic                               dropped;
  } sorted_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // configuration port, idle from time zero
  logic                        psel    = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite  = 1'b0;
  logic [bsso_pkg::ADDR_W-1:0] paddr   = '0;
  logic [31:0]                 pwdata  = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  // input transactions
  logic                               start   = 1'b0;
  logic                               busy;
  logic signed [bsso_pkg::DATA_W-1:0] value   = '0;
  logic                               is_last = 1'b0;

  // results
  logic                               result_valid;
  logic signed [bsso_pkg::DATA_W-1:0] sorted_value;
  logic                               last_out;
  logic                               overflow;

  bubble_sort_selectable_order dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .start        (start),
    .busy         (busy),
    .value        (value),
    .is_last      (is_last),
    .result_valid (result_valid),
    .sorted_value (sorted_value),
    .last_out     (last_out),
    .overflow     (overflow)
  );

  // stimulus feed, predictor state and bookkeeping
  load_item_t                         load_queue [$];
  sorted_entry_t                      sorted_expect [$];
  logic signed [bsso_pkg::DATA_W-1:0] held_numbers [$];
  logic                               held_dropped = 1'b0;
  logic [1:0]                         cur_mode = bsso_pkg::MODE_ASC;

  load_item_t staged;
  bit         staged_valid = 1'b0;
  int         gap_left = 0;
  bit         took = 1'b0;

  int mismatch_count = 0;
  int results_checked = 0;
  int sets_sorted = 0;
  int sets_dropping = 0;
  int sets_by_mode [4] = '{0, 0, 0, 0};

  // free-running clock
  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  // one line per mismatch
  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // swap decision for a neighbor pair (a at j, b at j+1)
  function automatic bit order_swaps(input logic signed [bsso_pkg::DATA_W-1:0] a,
                                     input logic signed [bsso_pkg::DATA_W-1:0] b,
                                     input logic [1:0] mode);
    case (mode)
      bsso_pkg::MODE_ASC:  return a > b;
      bsso_pkg::MODE_DESC: return b > a;
      bsso_pkg::MODE_STRANGE: begin
        // zero operands never swap, and anything modulo minus one is zero
        if (a == 0 || b == 0 || b == -1)
          return 1'b0;
        return (a % b) > 0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // takes one accepted number; a last mark sorts the held set into expectations
  task automatic absorb_number(input logic signed [bsso_pkg::DATA_W-1:0] num,
                               input logic last);
    logic signed [bsso_pkg::DATA_W-1:0] work [$];
    logic signed [bsso_pkg::DATA_W-1:0] tmp;
    sorted_entry_t                      entry;
    int                                 n;
    if (held_numbers.size() < bsso_pkg::CAPACITY)
      held_numbers.push_back(num);
    else
      held_dropped = 1'b1;
    if (last) begin
      work = held_numbers;
      n = work.size();
      // n full passes, every neighbor pair in each
      for (int p = 0; p < n; p++) begin
        for (int j = 0; j + 1 < n; j++) begin
          if (order_swaps(work[j], work[j+1], cur_mode)) begin
            tmp       = work[j];
            work[j]   = work[j+1];
            work[j+1] = tmp;
          end
        end
      end
      for (int j = 0; j < n; j++) begin
        entry.number  = work[j];
        entry.last    = (j == n - 1);
        entry.dropped = held_dropped;
        sorted_expect.push_back(entry);
      end
      sets_sorted++;
      sets_by_mode[cur_mode]++;
      if (held_dropped)
        sets_dropping++;
      // the burst empties the store and clears the dropped flag
      held_numbers.delete();
      held_dropped = 1'b0;
    end
  endtask

  // compares one result transaction with the oldest expectation
  task automatic check_result();
    sorted_entry_t want;
    if (sorted_expect.size() == 0) begin
      report_mismatch($sformatf("result %0d with nothing expected", sorted_value));
    end else begin
      want = sorted_expect.pop_front();
      results_checked++;
      if (sorted_value !== want.number)
        report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                  sorted_value, want.number));
      if (last_out !== want.last)
        report_mismatch($sformatf("last_out %b, expected %b on %0d",
                                  last_out, want.last, want.number));
      if (overflow !== want.dropped)
        report_mismatch($sformatf("overflow %b, expected %b on %0d",
                                  overflow, want.dropped, want.number));
    end
  endtask

  // monitor: results and accepted transactions, sampled at the rising edge
  always @(posedge clk) begin
    took = 1'b0;
    if (!rst) begin
      if (result_valid)
        check_result();
      if (start && !busy) begin
        took = 1'b1;
        absorb_number(value, is_last);
      end
    end
  end

  // driver: holds start until accepted, then takes the next item after its gap
  always @(negedge clk) begin
    if (!rst && !(start && !took)) begin
      if (!staged_valid && load_queue.size() > 0) begin
        staged       = load_queue.pop_front();
        staged_valid = 1'b1;
        gap_left     = staged.gap;
      end
      if (staged_valid && gap_left == 0) begin
        start        <= 1'b1;
        value        <= staged.number;
        is_last      <= staged.last;
        staged_valid = 1'b0;
      end else begin
        // idle cycle: start low, data lines carry junk
        start   <= 1'b0;
        value   <= $urandom();
        is_last <= 1'($urandom_range(0, 1));
        if (gap_left > 0)
          gap_left--;
      end
    end
  end

  // mostly back to back or short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // extremes, small values near zero and full-range noise
  function automatic logic signed [bsso_pkg::DATA_W-1:0] pick_number();
    int k;
    case ($urandom_range(0, 9))
      0: return ($urandom_range(0, 1) != 0) ? NUM_MAX : NUM_MIN;
      1: return ($urandom_range(0, 1) != 0) ? 0 : -1;
      2, 3: begin
        k = $urandom_range(0, 40);
        return k - 20;
      end
      4: begin
        k = $urandom_range(0, 3);
        return ($urandom_range(0, 1) != 0) ? NUM_MAX - k : NUM_MIN + k;
      end
      default: return $urandom();
    endcase
  endfunction

  // queues one set, last mark on its final number
  task automatic queue_set(input logic signed [bsso_pkg::DATA_W-1:0] nums [$],
                           input bit no_idle);
    load_item_t item;
    for (int k = 0; k < nums.size(); k++) begin
      item.number = nums[k];
      item.last   = (k == nums.size() - 1);
      item.gap    = no_idle ? 0 : pick_gap();
      load_queue.push_back(item);
    end
  endtask

  // random sets, mostly small, a few beyond capacity; optionally a first set that overfills the store
  task automatic queue_random_sets(input int target, input bit with_overflow);
    logic signed [bsso_pkg::DATA_W-1:0] nums [$];
    int made;
    int size;
    int r;
    made = 0;
    while (made < target) begin
      r = $urandom_range(0, 99);
      if (with_overflow && made == 0)
        size = $urandom_range(bsso_pkg::CAPACITY + 1, bsso_pkg::CAPACITY + 4);
      else if (r < 65)
        size = $urandom_range(1, 8);
      else if (r < 88)
        size = $urandom_range(9, 20);
      else if (r < 97)
        size = $urandom_range(21, bsso_pkg::CAPACITY);
      else
        size = $urandom_range(bsso_pkg::CAPACITY, bsso_pkg::CAPACITY + 3);
      nums.delete();
      for (int k = 0; k < size; k++)
        nums.push_back(pick_number());
      queue_set(nums, $urandom_range(0, 3) == 0);
      made += size;
    end
  endtask

  function automatic bit sender_idle();
    return load_queue.size() == 0 && !staged_valid && !start;
  endfunction

  // waits until every transaction is in and every result out, then a short pause
  task automatic settle();
    while (!(sender_idle() && sorted_expect.size() == 0 && !busy))
      @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  // two-phase apb access, completing when pready is seen in the access phase
  task automatic apb_access(input logic wr, input logic [bsso_pkg::ADDR_W-1:0] addr,
                            input logic [31:0] data, output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // register write while idle; compare_mode is read back afterwards
  task automatic write_reg(input logic [bsso_pkg::ADDR_W-1:0] addr,
                           input logic [31:0] data);
    logic [31:0] rdata;
    apb_access(1'b1, addr, data, rdata);
    if (addr == ADDR_COMPARE_MODE)
      cur_mode = data[1:0];
    apb_access(1'b0, ADDR_COMPARE_MODE, '0, rdata);
    if (rdata !== {30'd0, cur_mode})
      report_mismatch($sformatf("compare_mode reads %0h, expected %0h", rdata, cur_mode));
  endtask

  // watchdog
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // main sequence
  initial begin
    logic signed [bsso_pkg::DATA_W-1:0] nums [$];
    logic [1:0] plan [RANDOM_PHASES];
    int waited;
    plan = '{bsso_pkg::MODE_ASC, bsso_pkg::MODE_STRANGE, bsso_pkg::MODE_DESC,
             MODE_UNUSED, bsso_pkg::MODE_STRANGE, bsso_pkg::MODE_ASC,
             bsso_pkg::MODE_DESC};

    // synchronous reset, released on a falling edge
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ascending from reset: extremes, zero, minus one, and a lone number
    nums = '{NUM_MAX, NUM_MIN, 0, -1, 1, 7};
    queue_set(nums, 1'b0);
    nums = '{NUM_MIN};
    queue_set(nums, 1'b0);
    settle();

    // descending, upper data bits junk
    write_reg(ADDR_COMPARE_MODE, 32'hffff_fffd);
    nums = '{NUM_MAX, NUM_MIN, 0, -1, 1, 7};
    queue_set(nums, 1'b1);
    settle();

    // remainder order: most negative next to minus one, a zero, mixed signs
    write_reg(ADDR_COMPARE_MODE, {30'd0, bsso_pkg::MODE_STRANGE});
    nums = '{NUM_MIN, -1, 5, -3, 0, 7, 2};
    queue_set(nums, 1'b0);
    settle();

    // unused mode keeps load order
    write_reg(ADDR_COMPARE_MODE, {30'd0, MODE_UNUSED});
    nums = '{3, 1, 2};
    queue_set(nums, 1'b0);
    settle();

    // a write to the empty address must leave the order alone
    write_reg(ADDR_NO_REG, 32'h0000_0000);
    nums = '{2, 1};
    queue_set(nums, 1'b0);
    settle();

    // random phases, one order each; the sender drains fully between them
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 4)
        write_reg(ADDR_NO_REG, $urandom());
      write_reg(ADDR_COMPARE_MODE, {$urandom_range(0, 1) ? 30'h3fff_ffff : 30'd0, plan[ph]});
      queue_random_sets(PHASE_ITEMS, ph < 2);
      settle();
    end

    // last drain, bounded so leftovers get reported
    waited = 0;
    while (!(sender_idle() && sorted_expect.size() == 0) && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sorted_expect.size() != 0)
      report_mismatch($sformatf("%0d sorted results never arrived", sorted_expect.size()));
    repeat (4 * SETTLE_GAP) @(posedge clk);

    $display("sorted %0d sets (%0d lost numbers to a full store), checked %0d results",
             sets_sorted, sets_dropping, results_checked);
    $display("sets per order ascending/descending/remainder/unused: %0d/%0d/%0d/%0d",
             sets_by_mode[0], sets_by_mode[1], sets_by_mode[2], sets_by_mode[3]);
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
rtl/bsso_pkg.sv
rtl/bsso_cmp_unit.sv
rtl/bubble_sort_selectable_order.sv
bench/bubble_sort_selectable_order_tb.sv
